@@ rtl/aks_pkg.sv @@
package aks_pkg;

    localparam int NUM_ACCOUNTS = 1024;
    localparam int ADDR_W       = $clog2(NUM_ACCOUNTS);

    localparam int ACTION_W  = 3;
    localparam int ACCOUNT_W = 10;
    localparam int CAUSE_W   = 4;
    localparam int TIME_W    = 63;
    localparam int COUNT_W   = 16;

    localparam int IN_DATA_W  = 80;
    localparam int OUT_DATA_W = 160;

    localparam int CFG_ADDR_W = 2;
    localparam int CFG_DATA_W = 32;

    localparam logic [CFG_ADDR_W-1:0] REG_TRIP_THRESHOLD = CFG_ADDR_W'(0);

    localparam logic [CAUSE_W-1:0] CAUSE_REPEATED_REJECTS = CAUSE_W'(1);
    localparam logic [COUNT_W-1:0] COUNT_MAX = {COUNT_W{1'b1}};

    typedef enum logic [ACTION_W-1:0] {
        ACT_HALT_VENUE   = 3'd0,
        ACT_RESUME_VENUE = 3'd1,
        ACT_HALT_ACCT    = 3'd2,
        ACT_RESUME_ACCT  = 3'd3,
        ACT_REJECT       = 3'd4,
        ACT_ACCEPT       = 3'd5,
        ACT_QUERY        = 3'd6
    } action_t;

    typedef struct packed {
        logic               flag;
        logic [CAUSE_W-1:0] cause;
        logic [TIME_W-1:0]  since;
        logic [COUNT_W-1:0] count;
    } entry_t;

endpackage

@@ rtl/aks_ram.sv @@
module aks_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

@@ rtl/aks_entry_update.sv @@
module aks_entry_update (
    input  aks_pkg::action_t                action,
    input  logic                            acct_valid,
    input  logic [aks_pkg::CAUSE_W-1:0]     halt_cause,
    input  logic [aks_pkg::TIME_W-1:0]      event_time,
    input  logic [aks_pkg::COUNT_W-1:0]     trip_threshold,
    input  aks_pkg::entry_t                 cur_entry,
    output aks_pkg::entry_t                 new_entry
);
    import aks_pkg::*;

    logic [COUNT_W-1:0] bumped;

    assign bumped = (cur_entry.count != COUNT_MAX) ? cur_entry.count + COUNT_W'(1)
                                                   : cur_entry.count;

    always_comb
    begin
        new_entry = cur_entry;
        if (acct_valid)
        begin
            unique case (action)
                ACT_HALT_ACCT:
                begin
                    new_entry.flag  = 1'b1;
                    new_entry.cause = halt_cause;
                    new_entry.since = event_time;
                end
                ACT_RESUME_ACCT:
                begin
                    new_entry = '0;
                end
                ACT_REJECT:
                begin
                    if (trip_threshold != '0 && !cur_entry.flag)
                    begin
                        new_entry.count = bumped;
                        if (bumped >= trip_threshold)
                        begin
                            new_entry.flag  = 1'b1;
                            new_entry.cause = CAUSE_REPEATED_REJECTS;
                            new_entry.since = event_time;
                        end
                    end
                end
                ACT_ACCEPT:
                begin
                    new_entry.count = '0;
                end
                default:
                begin
                    new_entry = cur_entry;
                end
            endcase
        end
    end

endmodule

@@ rtl/account_kill_switch.sv @@
// Channel   Dir  Beat contents
// s_*       in   tuser: action; tdata: account, halt_cause, event_time
// m_*       out  tdata: blocks_orders, venue and account state, reject_run
// APB       in   trip_threshold at byte address 0
//
// One event per cycle when nothing stalls: an event reads its account entry
// from the table RAM when accepted, and writes it back as it leaves stage s1.
// A write-back register forwards the last entry written to a following
// event on the same account, so back-to-back events see fresh state.
// After reset a clearing pass writes zeros over all 1024 entries, one per
// cycle, and no event is accepted during the pass.
// A stalled result holds the second stage, which holds the input side.
module account_kill_switch (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              s_tvalid,
    output logic                              s_tready,
    // tdata from bit 0: account[9:0], halt_cause[13:10], event_time[76:14].
    input  logic [aks_pkg::IN_DATA_W-1:0]     s_tdata,
    // tuser: action[2:0].
    input  logic [aks_pkg::ACTION_W-1:0]      s_tuser,
    output logic                              m_tvalid,
    input  logic                              m_tready,
    // tdata from bit 0: blocks_orders[0], venue_is_halted[1], venue_cause[5:2],
    // venue_since[68:6], acct_is_halted[69], acct_cause[73:70],
    // acct_since[136:74], reject_run[152:137].
    output logic [aks_pkg::OUT_DATA_W-1:0]    m_tdata,
    input  logic                              psel,
    input  logic                              penable,
    input  logic                              pwrite,
    input  logic [aks_pkg::CFG_ADDR_W-1:0]    paddr,
    input  logic [aks_pkg::CFG_DATA_W-1:0]    pwdata,
    output logic [aks_pkg::CFG_DATA_W-1:0]    prdata,
    output logic                              pready
);
    import aks_pkg::*;

    logic               clearing_reg;
    logic [ADDR_W-1:0]  clr_addr_reg;
    logic [COUNT_W-1:0] threshold_reg;

    logic               s1_valid_reg;
    action_t            s1_action_reg;
    logic [ACCOUNT_W-1:0] s1_account_reg;
    logic [CAUSE_W-1:0] s1_cause_reg;
    logic [TIME_W-1:0]  s1_time_reg;

    logic               fwd_valid_reg;
    logic [ADDR_W-1:0]  fwd_addr_reg;
    entry_t             fwd_entry_reg;

    logic               venue_flag_reg;
    logic               venue_flag_next;
    logic [CAUSE_W-1:0] venue_cause_reg;
    logic [CAUSE_W-1:0] venue_cause_next;
    logic [TIME_W-1:0]  venue_since_reg;
    logic [TIME_W-1:0]  venue_since_next;

    logic               m_tvalid_reg;
    logic               m_tvalid_next;
    logic [OUT_DATA_W-1:0] m_tdata_reg;
    logic [OUT_DATA_W-1:0] m_tdata_next;

    logic               s_accept;
    logic               s1_adv;
    logic               s1_acct_valid;
    logic [ADDR_W-1:0]  s1_addr;
    logic               cfg_write;

    logic               mem_we;
    logic [ADDR_W-1:0]  mem_waddr;
    entry_t             mem_wdata;
    entry_t             mem_rdata;
    entry_t             cur_entry;
    entry_t             new_entry;
    entry_t             rep_entry;

    assign pready    = 1'b1;
    assign cfg_write = psel && penable && pwrite && pready;
    assign prdata    = (paddr == REG_TRIP_THRESHOLD) ? CFG_DATA_W'(threshold_reg) : '0;

    assign s1_adv   = s1_valid_reg && (!m_tvalid_reg || m_tready);
    assign s_tready = !clearing_reg && (!s1_valid_reg || s1_adv);
    assign s_accept = s_tvalid && s_tready;

    assign s1_addr       = s1_account_reg[ADDR_W-1:0];
    assign s1_acct_valid = {1'b0, s1_account_reg} < (ACCOUNT_W + 1)'(NUM_ACCOUNTS);

    assign cur_entry = (fwd_valid_reg && fwd_addr_reg == s1_addr) ? fwd_entry_reg : mem_rdata;

    aks_entry_update u_update (
        .action         (s1_action_reg),
        .acct_valid     (s1_acct_valid),
        .halt_cause     (s1_cause_reg),
        .event_time     (s1_time_reg),
        .trip_threshold (threshold_reg),
        .cur_entry      (cur_entry),
        .new_entry      (new_entry)
    );

    assign mem_we    = clearing_reg || (s1_adv && s1_acct_valid);
    assign mem_waddr = clearing_reg ? clr_addr_reg : s1_addr;
    assign mem_wdata = clearing_reg ? entry_t'('0) : new_entry;

    aks_ram #(
        .WIDTH ($bits(entry_t)),
        .DEPTH (NUM_ACCOUNTS)
    ) u_table (
        .clk   (clk),
        .we    (mem_we),
        .waddr (mem_waddr),
        .wdata (mem_wdata),
        .re    (s_accept),
        .raddr (s_tdata[ADDR_W-1:0]),
        .rdata (mem_rdata)
    );

    always_comb
    begin
        venue_flag_next  = venue_flag_reg;
        venue_cause_next = venue_cause_reg;
        venue_since_next = venue_since_reg;
        if (s1_adv)
        begin
            case (s1_action_reg)
                ACT_HALT_VENUE:
                begin
                    venue_flag_next  = 1'b1;
                    venue_cause_next = s1_cause_reg;
                    venue_since_next = s1_time_reg;
                end
                ACT_RESUME_VENUE:
                begin
                    venue_flag_next  = 1'b0;
                    venue_cause_next = '0;
                    venue_since_next = '0;
                end
                default:
                begin
                    venue_flag_next = venue_flag_reg;
                end
            endcase
        end
    end

    assign rep_entry = s1_acct_valid ? new_entry : entry_t'('0);

    always_comb
    begin
        m_tdata_next = {
            {(OUT_DATA_W - 153){1'b0}},
            rep_entry.count,
            rep_entry.since,
            rep_entry.cause,
            rep_entry.flag,
            venue_since_next,
            venue_cause_next,
            venue_flag_next,
            venue_flag_next || rep_entry.flag
        };
        if (s1_adv)
        begin
            m_tvalid_next = 1'b1;
        end
        else if (m_tready)
        begin
            m_tvalid_next = 1'b0;
        end
        else
        begin
            m_tvalid_next = m_tvalid_reg;
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            clearing_reg    <= 1'b1;
            clr_addr_reg    <= '0;
            threshold_reg   <= '0;
            s1_valid_reg    <= 1'b0;
            fwd_valid_reg   <= 1'b0;
            venue_flag_reg  <= 1'b0;
            venue_cause_reg <= '0;
            venue_since_reg <= '0;
            m_tvalid_reg    <= 1'b0;
        end
        else
        begin
            if (clearing_reg)
            begin
                clr_addr_reg <= clr_addr_reg + ADDR_W'(1);
                if (clr_addr_reg == ADDR_W'(NUM_ACCOUNTS - 1))
                begin
                    clearing_reg <= 1'b0;
                end
            end
            if (cfg_write && paddr == REG_TRIP_THRESHOLD)
            begin
                threshold_reg <= pwdata[COUNT_W-1:0];
            end
            if (s_accept)
            begin
                s1_valid_reg <= 1'b1;
            end
            else if (s1_adv)
            begin
                s1_valid_reg <= 1'b0;
            end
            if (s1_adv && s1_acct_valid)
            begin
                fwd_valid_reg <= 1'b1;
            end
            venue_flag_reg  <= venue_flag_next;
            venue_cause_reg <= venue_cause_next;
            venue_since_reg <= venue_since_next;
            m_tvalid_reg    <= m_tvalid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (s_accept)
        begin
            s1_action_reg  <= action_t'(s_tuser);
            s1_account_reg <= s_tdata[ACCOUNT_W-1:0];
            s1_cause_reg   <= s_tdata[ACCOUNT_W +: CAUSE_W];
            s1_time_reg    <= s_tdata[ACCOUNT_W + CAUSE_W +: TIME_W];
        end
        if (s1_adv && s1_acct_valid)
        begin
            fwd_addr_reg  <= s1_addr;
            fwd_entry_reg <= new_entry;
        end
        if (s1_adv)
        begin
            m_tdata_reg <= m_tdata_next;
        end
    end

    a_no_item_while_clearing: assert property (@(posedge clk) disable iff (!rst_n)
        clearing_reg |-> !s1_valid_reg && !fwd_valid_reg)
        else $error("event in flight during table clearing pass");

    a_accept_loads_stage: assert property (@(posedge clk) disable iff (!rst_n)
        s_accept |=> s1_valid_reg)
        else $error("accepted event did not reach the update stage");

    a_item_write_only_on_advance: assert property (@(posedge clk) disable iff (!rst_n)
        (mem_we && !clearing_reg) |-> s1_adv)
        else $error("table written without an event completing");

    a_venue_idle_fields_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (m_tvalid && !m_tdata[1]) |-> (m_tdata[68:2] == '0))
        else $error("venue cause or time nonzero while venue not halted");

    a_blocks_matches_flags: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid |-> (m_tdata[0] == (m_tdata[1] || m_tdata[69])))
        else $error("blocks_orders disagrees with halt flags");

endmodule
